// ===== hw/rtl/rwif_pkg.sv =====
// ----------------------------------------------------------------------------
// rwif_pkg
// Shared constants for the register window index flatten unit.
// ----------------------------------------------------------------------------
package rwif_pkg;

    localparam int ARCH_REG_COUNT   = 32;
    localparam int GLOBALS_PER_SET  = 8;
    localparam int WINDOW_STRIDE    = 16;

    localparam int WINDOW_COUNT_DEF     = 8;
    localparam int MAX_GLOBAL_LEVEL_DEF = 3;
    localparam int MICRO_REG_COUNT_DEF  = 9;

    // index widened so that 3*ARCH_REG_COUNT+MICRO_REG_COUNT (<= 128) fits
    localparam int IDX_EXT_W = 8;
    // saturated global level, MAX_GLOBAL_LEVEL <= 7
    localparam int LEVEL_W   = 3;
    // window pointer widened for compare with WINDOW_COUNT <= 32
    localparam int CWP_EXT_W = 6;
    localparam int OFF_W     = 5;
    localparam int FLAT_W    = 8;

endpackage

// ===== hw/rtl/register_window_index_flatten_unit.sv =====
// ----------------------------------------------------------------------------
// register_window_index_flatten_unit
// Maps an architectural register index to a flat register-file index.
//
// Command channel: an item (arch_index, global_level, window_pointer) is
// taken on a rising edge with start high and busy low. busy is always low,
// so an item may be issued every cycle.
// Result channel: done is high for one cycle with flat_index and invalid.
// The receiver cannot stall; each result shows for exactly one cycle.
// The result passes through the input register, then the result register.
// Throughput: 1 item per cycle, set by the single mapping stage between
// the two registers.
// Reset clears the valid pipeline; no item is in flight after reset.
// invalid is set, with flat_index zero, for indices past the last region.
// ----------------------------------------------------------------------------
module register_window_index_flatten_unit #(
    parameter int WINDOW_COUNT     = rwif_pkg::WINDOW_COUNT_DEF,
    parameter int MAX_GLOBAL_LEVEL = rwif_pkg::MAX_GLOBAL_LEVEL_DEF,
    parameter int MICRO_REG_COUNT  = rwif_pkg::MICRO_REG_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [6:0] arch_index,
    input  logic [1:0] global_level,
    input  logic [2:0] window_pointer,
    output logic       done,
    output logic [7:0] flat_index,
    output logic       invalid
);

    logic       in_valid_reg;
    logic [6:0] arch_index_reg;
    logic [1:0] global_level_reg;
    logic [2:0] window_pointer_reg;
    logic       done_reg;
    logic [7:0] flat_index_reg;
    logic       invalid_reg;
    logic [7:0] flat_index_next;
    logic       invalid_next;
    logic       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arch_index_reg     <= arch_index;
            global_level_reg   <= global_level;
            window_pointer_reg <= window_pointer;
        end
        if (in_valid_reg)
        begin
            flat_index_reg <= flat_index_next;
            invalid_reg    <= invalid_next;
        end
    end

    rwif_map #(
        .WINDOW_COUNT     (WINDOW_COUNT),
        .MAX_GLOBAL_LEVEL (MAX_GLOBAL_LEVEL),
        .MICRO_REG_COUNT  (MICRO_REG_COUNT)
    ) u_map (
        .arch_index     (arch_index_reg),
        .global_level   (global_level_reg),
        .window_pointer (window_pointer_reg),
        .flat_index     (flat_index_next),
        .invalid        (invalid_next)
    );

    assign done       = done_reg;
    assign flat_index = flat_index_reg;
    assign invalid    = invalid_reg;

endmodule

// ===== hw/rtl/rwif_map.sv =====
// ----------------------------------------------------------------------------
// rwif_map
// Combinational index translation: region decode, window wrap and
// global level select for one item.
// ----------------------------------------------------------------------------
module rwif_map #(
    parameter int WINDOW_COUNT     = rwif_pkg::WINDOW_COUNT_DEF,
    parameter int MAX_GLOBAL_LEVEL = rwif_pkg::MAX_GLOBAL_LEVEL_DEF,
    parameter int MICRO_REG_COUNT  = rwif_pkg::MICRO_REG_COUNT_DEF
) (
    input  logic [6:0] arch_index,
    input  logic [1:0] global_level,
    input  logic [2:0] window_pointer,
    output logic [7:0] flat_index,
    output logic       invalid
);

    localparam int A     = rwif_pkg::ARCH_REG_COUNT;
    localparam int SPAN  = WINDOW_COUNT * rwif_pkg::WINDOW_STRIDE;
    localparam int NGLOB = (MAX_GLOBAL_LEVEL + 1) * rwif_pkg::GLOBALS_PER_SET;
    localparam int SUM_W = $clog2(2 * SPAN + NGLOB + MICRO_REG_COUNT + A);
    localparam int WIN_W = $clog2(WINDOW_COUNT);
    localparam int IW    = rwif_pkg::IDX_EXT_W;
    localparam int CW    = rwif_pkg::CWP_EXT_W;
    localparam int LW    = rwif_pkg::LEVEL_W;
    localparam int OW    = rwif_pkg::OFF_W;

    localparam logic [IW-1:0] MICRO_BASE = IW'(A);
    localparam logic [IW-1:0] PREV_BASE  = IW'(A + MICRO_REG_COUNT);
    localparam logic [IW-1:0] NEXT_BASE  = IW'(2 * A + MICRO_REG_COUNT);
    localparam logic [IW-1:0] END_BASE   = IW'(3 * A + MICRO_REG_COUNT);

    logic [CW-1:0]    cwp_wide;
    logic [WIN_W-1:0] cwp;
    logic [WIN_W-1:0] prev_win;
    logic [WIN_W-1:0] next_win;
    logic [LW-1:0]    gl_sat;
    logic [IW-1:0]    idx_x;
    logic [OW-1:0]    off;
    logic [WIN_W-1:0] win;
    logic             is_micro;
    logic             bad;
    logic [SUM_W-1:0] glob_slot;
    logic [SUM_W-1:0] wsum;
    logic [SUM_W-1:0] wslot;
    logic [SUM_W-1:0] micro_slot;
    logic [SUM_W-1:0] slot;

    // pointer modulo window count, at most three subtractions for a 3-bit value
    always_comb
    begin
        cwp_wide = CW'(window_pointer);
        for (int k = 0; k < 4; k++)
        begin
            if (cwp_wide >= CW'(WINDOW_COUNT))
            begin
                cwp_wide = cwp_wide - CW'(WINDOW_COUNT);
            end
        end
    end

    assign cwp      = cwp_wide[WIN_W-1:0];
    assign prev_win = (cwp == '0) ? WIN_W'(WINDOW_COUNT - 1) : cwp - WIN_W'(1);
    assign next_win = (cwp == WIN_W'(WINDOW_COUNT - 1)) ? '0 : cwp + WIN_W'(1);

    assign gl_sat = (LW'(global_level) > LW'(MAX_GLOBAL_LEVEL)) ?
                    LW'(MAX_GLOBAL_LEVEL) : LW'(global_level);

    assign idx_x = IW'(arch_index);

    always_comb
    begin
        off      = '0;
        win      = cwp;
        is_micro = 1'b0;
        bad      = 1'b0;
        priority if (idx_x < MICRO_BASE)
        begin
            off = idx_x[OW-1:0];
        end
        else if (idx_x < PREV_BASE)
        begin
            is_micro = 1'b1;
        end
        else if (idx_x < NEXT_BASE)
        begin
            off = OW'(idx_x - PREV_BASE);
            win = prev_win;
        end
        else if (idx_x < END_BASE)
        begin
            off = OW'(idx_x - NEXT_BASE);
            win = next_win;
        end
        else
        begin
            bad = 1'b1;
        end
    end

    assign glob_slot = SUM_W'({gl_sat, off[2:0]});

    // (off - 8 - 16*win) mod SPAN; the sum stays below 2*SPAN
    assign wsum  = SUM_W'(OW'(off - OW'(8))) + SUM_W'(SPAN) - (SUM_W'(win) << 4);
    assign wslot = ((wsum >= SUM_W'(SPAN)) ? wsum - SUM_W'(SPAN) : wsum) + SUM_W'(NGLOB);

    assign micro_slot = SUM_W'(idx_x - MICRO_BASE) + SUM_W'(NGLOB + SPAN);

    always_comb
    begin
        priority if (bad)
        begin
            slot = '0;
        end
        else if (is_micro)
        begin
            slot = micro_slot;
        end
        else if (off < OW'(8))
        begin
            slot = glob_slot;
        end
        else
        begin
            slot = wslot;
        end
    end

    assign flat_index = rwif_pkg::FLAT_W'(slot);
    assign invalid    = bad;

endmodule

// ===== hw/rtl/rwif_checker.sv =====
// ----------------------------------------------------------------------------
// rwif_checker
// Port-level checks for the register window index flatten unit.
// ----------------------------------------------------------------------------
module rwif_checker #(
    parameter int MICRO_REG_COUNT = rwif_pkg::MICRO_REG_COUNT_DEF
) (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [6:0] arch_index,
    input logic       done,
    input logic [7:0] flat_index,
    input logic       invalid
);

    localparam logic [7:0] END_BASE = 8'(3 * rwif_pkg::ARCH_REG_COUNT + MICRO_REG_COUNT);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("item without result two cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an item");

    a_invalid_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (invalid == ({1'b0, $past(arch_index, 2)} >= END_BASE)))
        else $error("invalid flag does not match index range");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid) |-> (flat_index == 8'd0))
        else $error("nonzero index on invalid result");

endmodule

bind register_window_index_flatten_unit rwif_checker #(
    .MICRO_REG_COUNT (MICRO_REG_COUNT)
) u_rwif_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .arch_index (arch_index),
    .done       (done),
    .flat_index (flat_index),
    .invalid    (invalid)
);

// ===== dv/rwif_checker.sv =====
// ----------------------------------------------------------------------------
// rwif_scoreboard
// Watches the command and result channels of the register window index
// flatten unit. Predicts the flat index for each accepted item and checks
// every strobed result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module rwif_scoreboard (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [6:0] arch_index,
    input  logic [1:0] global_level,
    input  logic [2:0] window_pointer,
    input  logic       done,
    input  logic [7:0] flat_index,
    input  logic       invalid,
    output int         fail_count,
    output int         pending,
    output int         results_seen,
    output int         invalid_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rwif_pkg::FLAT_W-1:0] flat;
        logic                        bad;
    } flat_result_t;

    localparam int NUM_GLOBALS = (rwif_pkg::MAX_GLOBAL_LEVEL_DEF + 1)
                                 * rwif_pkg::GLOBALS_PER_SET;
    localparam int WINDOW_SPAN = rwif_pkg::WINDOW_COUNT_DEF * rwif_pkg::WINDOW_STRIDE;

    flat_result_t flat_q[$];

    function automatic int window_or_global(int off, int lvl, int win);
        if (off < rwif_pkg::GLOBALS_PER_SET)
            return off + lvl * rwif_pkg::GLOBALS_PER_SET;
        return NUM_GLOBALS
            + ((off - rwif_pkg::GLOBALS_PER_SET
                + (rwif_pkg::WINDOW_COUNT_DEF - win) * rwif_pkg::WINDOW_STRIDE)
               % WINDOW_SPAN);
    endfunction

    function automatic flat_result_t map_arch_index(logic [6:0] idx, logic [1:0] lvl,
                                                    logic [2:0] wp);
        int a;
        int m;
        int i;
        int gl;
        int cwp;
        int prev_win;
        int next_win;
        int flat;
        flat_result_t r;
        a        = rwif_pkg::ARCH_REG_COUNT;
        m        = rwif_pkg::MICRO_REG_COUNT_DEF;
        i        = int'(idx);
        gl       = int'(lvl);
        cwp      = int'(wp) % rwif_pkg::WINDOW_COUNT_DEF;
        prev_win = (cwp + rwif_pkg::WINDOW_COUNT_DEF - 1) % rwif_pkg::WINDOW_COUNT_DEF;
        next_win = (cwp + 1) % rwif_pkg::WINDOW_COUNT_DEF;
        flat     = 0;
        r.bad    = 1'b0;
        if (gl > rwif_pkg::MAX_GLOBAL_LEVEL_DEF)
            gl = rwif_pkg::MAX_GLOBAL_LEVEL_DEF;
        if (i < a)
            flat = window_or_global(i, gl, cwp);
        else if (i < a + m)
            flat = i - a + NUM_GLOBALS + WINDOW_SPAN;
        else if (i < 2 * a + m)
            flat = window_or_global(i - (a + m), gl, prev_win);
        else if (i < 3 * a + m)
            flat = window_or_global(i - (2 * a + m), gl, next_win);
        else
            r.bad = 1'b1;
        r.flat = flat[rwif_pkg::FLAT_W-1:0];
        return r;
    endfunction

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        invalid_seen = 0;
    end

    always @(posedge clk)
    begin
        flat_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen = results_seen + 1;
                if (invalid)
                    invalid_seen = invalid_seen + 1;
                if (flat_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: result with no item waiting: flat_index=%0d invalid=%0b",
                             $time, flat_index, invalid);
                end
                else
                begin
                    want = flat_q.pop_front();
                    if (flat_index !== want.flat)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: flat_index mismatch: expected %0d, actual %0d",
                                 $time, want.flat, flat_index);
                    end
                    if (invalid !== want.bad)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: invalid mismatch: expected %0b, actual %0b",
                                 $time, want.bad, invalid);
                    end
                end
            end
            if (start && !busy)
                flat_q.push_back(map_arch_index(arch_index, global_level, window_pointer));
            pending = flat_q.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the register window index flatten unit. Drives
// region boundaries, both window wrap directions and out-of-range indices,
// then random items under three start-gap profiles; checking is done by
// rwif_scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [6:0] arch_index;
    logic [1:0] global_level;
    logic [2:0] window_pointer;
    logic       done;
    logic [7:0] flat_index;
    logic       invalid;

    int fail_count;
    int pending;
    int results_seen;
    int invalid_seen;
    int items_sent;

    // region edges: current, microcode, previous window, next window, out of range
    int boundary_idx [18] = '{0, 7, 8, 23, 24, 31, 32, 40, 41, 48, 49,
                              72, 73, 80, 81, 104, 105, 127};

    register_window_index_flatten_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .arch_index     (arch_index),
        .global_level   (global_level),
        .window_pointer (window_pointer),
        .done           (done),
        .flat_index     (flat_index),
        .invalid        (invalid)
    );

    rwif_scoreboard u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .arch_index     (arch_index),
        .global_level   (global_level),
        .window_pointer (window_pointer),
        .done           (done),
        .flat_index     (flat_index),
        .invalid        (invalid),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .invalid_seen   (invalid_seen)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic issue_item(int idx, int lvl, int wp);
        @(negedge clk);
        arch_index     <= idx[6:0];
        global_level   <= lvl[1:0];
        window_pointer <= wp[2:0];
        start          <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        items_sent = items_sent + 1;
    endtask

    // start low with junk on the operand ports
    task automatic hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            start          <= 1'b0;
            arch_index     <= 7'($urandom);
            global_level   <= 2'($urandom);
            window_pointer <= 3'($urandom);
        end
    endtask

    // each cycle is idle with probability gap_pct percent
    task automatic random_items(int n, int gap_pct);
        int idx;
        repeat (n)
        begin
            while ($urandom_range(0, 99) < gap_pct)
                hold_off(1);
            if ($urandom_range(0, 3) == 0)
                idx = boundary_idx[$urandom_range(0, 17)];
            else
                idx = $urandom_range(0, 127);
            issue_item(idx, $urandom_range(0, 3), $urandom_range(0, 7));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        arch_index     = '0;
        global_level   = '0;
        window_pointer = '0;
        items_sent     = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (boundary_idx[k])
            issue_item(boundary_idx[k], (k % 2) * 3, (k % 3 == 0) ? 0 : 7);
        issue_item(8, 0, 0);
        issue_item(41, 3, 0);
        issue_item(73, 0, 7);
        issue_item(104, 3, 7);
        issue_item(5, 2, 4);
        issue_item(63, 1, 3);

        random_items(284, 6);
        random_items(283, 73);
        random_items(283, 0);

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("run covered %0d items and %0d results, %0d of them out of range,",
                 items_sent, results_seen, invalid_seen);
        $display("over every region edge, both window wraps and three start-gap profiles");
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #100us;
        $display("timeout with %0d results outstanding", pending);
        $display("status: fail");
        $finish;
    end

endmodule
